### rtl/nhp_pkg.sv
`timescale 1ns / 1ps

package nhp_pkg;

   // fixed widths of the result fields
   localparam int unsigned OUT_BITS = 31;

   // parser phases
   typedef enum logic [3:0] {
      PH_MAGIC = 4'd0,
      PH_TYPE  = 4'd1,
      PH_SEP_W = 4'd2,
      PH_NUM_W = 4'd3,
      PH_SEP_H = 4'd4,
      PH_NUM_H = 4'd5,
      PH_SEP_M = 4'd6,
      PH_NUM_M = 4'd7,
      PH_DONE  = 4'd8
   } phase_type;

   // result status codes
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_MALFORMED = 2'd1;
   localparam logic [1:0] ST_OVERFLOW  = 2'd2;

   // image type codes
   localparam logic [1:0] IMG_BILEVEL = 2'd0;

   // characters
   localparam logic [7:0] CH_P       = 8'h50;
   localparam logic [7:0] CH_4       = 8'h34;
   localparam logic [7:0] CH_5       = 8'h35;
   localparam logic [7:0] CH_6       = 8'h36;
   localparam logic [7:0] CH_HASH    = 8'h23;
   localparam logic [7:0] CH_NEWLINE = 8'h0a;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_TAB     = 8'h09;
   localparam logic [7:0] CH_0       = 8'h30;
   localparam logic [7:0] CH_9       = 8'h39;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_stream;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]          status;
      logic [1:0]          image_type;
      logic [OUT_BITS-1:0] width;
      logic [OUT_BITS-1:0] height;
      logic [OUT_BITS-1:0] max_value;
   } rsp_payload_type;

endpackage

### rtl/nhp_stream_if.sv
`timescale 1ns / 1ps

interface nhp_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

### rtl/netpbm_header_parser_top.sv
`timescale 1ns / 1ps
// netpbm header parser: one file byte per beat, one result beat per header
// result: registered, on rsp in the cycle after the byte beat that ends the header
// throughput: one byte beat per cycle while rsp is not stalled, set by the
//   single state update and times-ten accumulate before the result register
// reset (synchronous, active high): parser back to expecting the magic letter,
//   result register emptied

module netpbm_header_parser_top #(
   parameter int unsigned VALUE_BITS = 31
) (
   input  logic         clock,
   input  logic         reset,
   nhp_stream_if.sink   req_chan,
   nhp_stream_if.source rsp_chan
);

   localparam int unsigned WIDE_BITS = VALUE_BITS + 4;

   // parser state
   nhp_pkg::phase_type    phase_ff,       phase_in;
   logic                  in_comment_ff,  in_comment_in;
   logic [VALUE_BITS-1:0] acc_ff,         acc_in;
   logic [1:0]            type_seen_ff,   type_seen_in;
   logic [VALUE_BITS-1:0] width_seen_ff,  width_seen_in;
   logic [VALUE_BITS-1:0] height_seen_ff, height_seen_in;

   // result register
   logic                      rsp_valid_ff,   rsp_valid_in;
   nhp_pkg::rsp_payload_type  rsp_payload_ff, rsp_payload_in;

   // per-beat decode
   logic                  req_take;
   logic [7:0]            byte_val;
   logic                  is_digit, is_space, is_hash, is_newline;
   logic [3:0]            digit_val;
   logic [WIDE_BITS-1:0]  acc_next_wide;
   logic                  acc_overflow;

   // emit request from the parse logic
   logic                  emit;
   logic [1:0]            emit_status;
   logic [VALUE_BITS-1:0] emit_height;
   logic [VALUE_BITS-1:0] emit_max;

   // a new byte may enter whenever the result register is empty or draining
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign req_take       = req_chan.valid && req_chan.ready;

   assign byte_val   = req_chan.payload.data_byte;
   assign is_digit   = (byte_val >= nhp_pkg::CH_0) && (byte_val <= nhp_pkg::CH_9);
   assign is_newline = (byte_val == nhp_pkg::CH_NEWLINE);
   assign is_space   = (byte_val == nhp_pkg::CH_SPACE) || (byte_val == nhp_pkg::CH_TAB)
                       || is_newline;
   assign is_hash    = (byte_val == nhp_pkg::CH_HASH);
   assign digit_val  = 4'(byte_val - nhp_pkg::CH_0);

   // acc * 10 + digit, the top four bits flag a value past the value width
   assign acc_next_wide = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0}
                          + WIDE_BITS'(digit_val);
   assign acc_overflow  = |acc_next_wide[WIDE_BITS-1:VALUE_BITS];

   always_comb begin
      phase_in       = phase_ff;
      in_comment_in  = in_comment_ff;
      acc_in         = acc_ff;
      type_seen_in   = type_seen_ff;
      width_seen_in  = width_seen_ff;
      height_seen_in = height_seen_ff;
      emit           = 1'b0;
      emit_status    = nhp_pkg::ST_MALFORMED;
      emit_height    = height_seen_ff;
      emit_max       = '0;

      if (req_chan.payload.end_of_stream) begin
         // end of file: close any open header, then restart
         if (phase_ff != nhp_pkg::PH_DONE) begin
            emit = 1'b1;
            if (phase_ff == nhp_pkg::PH_NUM_M) begin
               emit_status = nhp_pkg::ST_OK;
               emit_max    = acc_ff;
            end else if (phase_ff == nhp_pkg::PH_NUM_H
                         && type_seen_ff == nhp_pkg::IMG_BILEVEL) begin
               emit_status = nhp_pkg::ST_OK;
               emit_height = acc_ff;
            end
         end
         phase_in       = nhp_pkg::PH_MAGIC;
         in_comment_in  = 1'b0;
         acc_in         = '0;
         type_seen_in   = '0;
         width_seen_in  = '0;
         height_seen_in = '0;
      end else begin
         case (phase_ff)
            nhp_pkg::PH_MAGIC: begin
               if (in_comment_ff) begin
                  if (is_newline) begin
                     in_comment_in = 1'b0;
                  end
               end else if (is_hash) begin
                  in_comment_in = 1'b1;
               end else if (byte_val == nhp_pkg::CH_P) begin
                  phase_in = nhp_pkg::PH_TYPE;
               end else begin
                  emit = 1'b1;
               end
            end
            nhp_pkg::PH_TYPE: begin
               if (byte_val == nhp_pkg::CH_4 || byte_val == nhp_pkg::CH_5
                   || byte_val == nhp_pkg::CH_6) begin
                  type_seen_in = 2'(byte_val - nhp_pkg::CH_4);
                  phase_in     = nhp_pkg::PH_SEP_W;
               end else begin
                  emit = 1'b1;
               end
            end
            nhp_pkg::PH_SEP_W, nhp_pkg::PH_SEP_H, nhp_pkg::PH_SEP_M: begin
               if (in_comment_ff) begin
                  if (is_newline) begin
                     in_comment_in = 1'b0;
                  end
               end else if (is_hash) begin
                  in_comment_in = 1'b1;
               end else if (is_digit) begin
                  acc_in = VALUE_BITS'(digit_val);
                  if (phase_ff == nhp_pkg::PH_SEP_W) begin
                     phase_in = nhp_pkg::PH_NUM_W;
                  end else if (phase_ff == nhp_pkg::PH_SEP_H) begin
                     phase_in = nhp_pkg::PH_NUM_H;
                  end else begin
                     phase_in = nhp_pkg::PH_NUM_M;
                  end
               end else if (!is_space) begin
                  emit = 1'b1;
               end
            end
            nhp_pkg::PH_NUM_W, nhp_pkg::PH_NUM_H, nhp_pkg::PH_NUM_M: begin
               if (is_digit) begin
                  if (acc_overflow) begin
                     emit        = 1'b1;
                     emit_status = nhp_pkg::ST_OVERFLOW;
                  end else begin
                     acc_in = acc_next_wide[VALUE_BITS-1:0];
                  end
               end else if (phase_ff == nhp_pkg::PH_NUM_M) begin
                  // any non-digit closes the last number
                  emit        = 1'b1;
                  emit_status = nhp_pkg::ST_OK;
                  emit_max    = acc_ff;
               end else if (phase_ff == nhp_pkg::PH_NUM_H
                            && type_seen_ff == nhp_pkg::IMG_BILEVEL) begin
                  height_seen_in = acc_ff;
                  emit           = 1'b1;
                  emit_status    = nhp_pkg::ST_OK;
                  emit_height    = acc_ff;
               end else begin
                  // terminator doubles as the first separator byte
                  if (phase_ff == nhp_pkg::PH_NUM_W) begin
                     width_seen_in = acc_ff;
                     phase_in      = nhp_pkg::PH_SEP_H;
                  end else begin
                     height_seen_in = acc_ff;
                     phase_in       = nhp_pkg::PH_SEP_M;
                  end
                  if (is_hash) begin
                     in_comment_in = 1'b1;
                  end else if (!is_space) begin
                     emit = 1'b1;
                  end
               end
            end
            default: begin
               // header finished, bytes ignored until end of stream
            end
         endcase

         if (emit) begin
            phase_in      = nhp_pkg::PH_DONE;
            in_comment_in = 1'b0;
         end
      end
   end

   // result beat: failed headers carry zero fields
   always_comb begin
      rsp_payload_in        = '0;
      rsp_payload_in.status = emit_status;
      if (emit_status == nhp_pkg::ST_OK) begin
         rsp_payload_in.image_type = type_seen_ff;
         rsp_payload_in.width      = nhp_pkg::OUT_BITS'(width_seen_ff);
         rsp_payload_in.height     = nhp_pkg::OUT_BITS'(emit_height);
         rsp_payload_in.max_value  = nhp_pkg::OUT_BITS'(emit_max);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_take && emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= nhp_pkg::PH_MAGIC;
         in_comment_ff  <= 1'b0;
         acc_ff         <= '0;
         type_seen_ff   <= '0;
         width_seen_ff  <= '0;
         height_seen_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (req_take) begin
            phase_ff       <= phase_in;
            in_comment_ff  <= in_comment_in;
            acc_ff         <= acc_in;
            type_seen_ff   <= type_seen_in;
            width_seen_ff  <= width_seen_in;
            height_seen_ff <= height_seen_in;
         end
      end
   end

   // payload register, no reset needed
   always_ff @(posedge clock) begin
      if (req_take && emit) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_payload_ff;

endmodule
